// ===== hw/rtl/ptcc_pkg.sv =====
package ptcc_pkg;

  // Fixed field widths
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int STAT_W = 2;

  // Longest prefix; longer lengths are clamped to it
  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_SEPARABLE = 2'd2;
  localparam logic [STAT_W-1:0] ST_CONFLICT  = 2'd3;

  // Which result the datapath latches on emit
  typedef enum logic [2:0] {
    RES_INSERTED = 3'd0,
    RES_DROPPED  = 3'd1,
    RES_SEP_WALK = 3'd2,
    RES_SEP_FULL = 3'd3,
    RES_CONFLICT = 3'd4
  } res_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      clr;
    logic      load;
    logic      step;
    logic      create;
    logic      mark;
    logic      emit;
    res_kind_t res_kind;
  } ptcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic mark_hit;
    logic at_end;
    logic child_none;
    logic pool_short;
    logic any_inserted;
    logic create_last;
    logic clr_last;
  } ptcc_stat_t;

  // Leading-ones mask of the given length (0 to 32)
  function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ===== hw/rtl/prefix_trie_conflict_check.sv =====
// Prefix trie conflict check.
// Command channel: an item (in_opcode, in_prefix_address, in_prefix_length)
// is taken at a rising edge with start high and busy low. Opcode insert adds
// an allowed prefix to a binary trie (MSB first); opcode query walks a
// blocked prefix and reports conflict or a separating prefix.
// Result channel: one beat per item, out_valid high for exactly one cycle
// with out_status, out_separating_address and out_separating_length. The
// receiver cannot stall; the beat is gone after that cycle.
// Timing: the walk advances one trie level per cycle, set by the registered
// read port of the node memory. A query walks until it hits a mark, a
// missing child or its length. An insert walks, creates each missing node
// at one node per cycle and then marks the end node. busy stays high until
// the result beat, and the next item may be taken in the cycle of that beat.
// Reset: a clearing sweep zeroes the node memory; busy is high throughout
// and no item is taken. A full pool drops an insert whole.
module prefix_trie_conflict_check
  import ptcc_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [ADDR_W-1:0] in_prefix_address,
  input  logic [LEN_W-1:0]  in_prefix_length,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_separating_address,
  output logic [LEN_W-1:0]  out_separating_length
);

  ptcc_cmd_t  cmd;
  ptcc_stat_t stat;

  ptcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ptcc_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_opcode              (in_opcode),
    .in_prefix_address      (in_prefix_address),
    .in_prefix_length       (in_prefix_length),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_separating_address (out_separating_address),
    .out_separating_length  (out_separating_length)
  );

  // A result beat only follows a cycle of work
  a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding work");

  // An accepted item holds the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Only separable results carry a separating prefix
  a_sep_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_SEPARABLE) |->
      (out_separating_address == '0 && out_separating_length == '0))
    else $error("separating fields set on a non-separable result");

endmodule

// ===== hw/rtl/ptcc_ctrl.sv =====
module ptcc_ctrl
  import ptcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  ptcc_stat_t stat,
  output ptcc_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_WALK   = 5'b00100,
    S_CREATE = 5'b01000,
    S_MARK   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // State register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_kind = RES_INSERTED;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.is_query) begin
          if (stat.mark_hit) begin
            cmd.emit     = 1'b1;
            cmd.res_kind = RES_CONFLICT;
            state_nxt    = S_IDLE;
          end else if (stat.at_end) begin
            cmd.emit     = 1'b1;
            cmd.res_kind = stat.any_inserted ? RES_CONFLICT : RES_SEP_FULL;
            state_nxt    = S_IDLE;
          end else if (stat.child_none) begin
            cmd.emit     = 1'b1;
            cmd.res_kind = RES_SEP_WALK;
            state_nxt    = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          if (stat.at_end || stat.child_none) begin
            if (stat.pool_short) begin
              cmd.emit     = 1'b1;
              cmd.res_kind = RES_DROPPED;
              state_nxt    = S_IDLE;
            end else if (stat.at_end) begin
              state_nxt = S_MARK;
            end else begin
              state_nxt = S_CREATE;
            end
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_CREATE: begin
        cmd.create = 1'b1;
        if (stat.create_last) state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark     = 1'b1;
        cmd.emit     = 1'b1;
        cmd.res_kind = RES_INSERTED;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ptcc_dpath.sv =====
module ptcc_dpath
  import ptcc_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptcc_cmd_t         cmd,
  output ptcc_stat_t        stat,
  input  logic              in_opcode,
  input  logic [ADDR_W-1:0] in_prefix_address,
  input  logic [LEN_W-1:0]  in_prefix_length,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_separating_address,
  output logic [LEN_W-1:0]  out_separating_length
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [AW-1:0] LAST_ID = AW'(NODE_COUNT - 1);

  // Node store: two child pointers and an end mark per node
  logic [AW-1:0] zero_mem [NODE_COUNT];
  logic [AW-1:0] one_mem  [NODE_COUNT];
  logic          mark_mem [NODE_COUNT];

  logic [AW-1:0]     rd_zero_r, rd_one_r;
  logic              rd_mark_r;
  logic              op_r;
  logic [ADDR_W-1:0] addr_r, addr_sh_r;
  logic [LEN_W-1:0]  len_r, depth_r;
  logic [AW-1:0]     node_r, nodes_used_r, clr_idx_r;
  logic              any_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [LEN_W-1:0]  out_len_r;

  logic              cur_bit;
  logic [AW-1:0]     child;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     new_id;
  logic [LEN_W-1:0]  needed;
  logic [AW-1:0]     free_nodes;
  logic [LEN_W-1:0]  in_len_clamped;
  logic [LEN_W-1:0]  depth_inc;
  logic              wr_zero_en, wr_one_en, wr_mark_en;
  logic [AW-1:0]     wr_addr, wr_ptr;
  logic              wr_mark;

  // Walk decode
  assign cur_bit        = addr_sh_r[ADDR_W-1];
  assign child          = cur_bit ? rd_one_r : rd_zero_r;
  assign new_id         = nodes_used_r + AW'(1);
  assign needed         = len_r - depth_r;
  assign free_nodes     = LAST_ID - nodes_used_r;
  assign depth_inc      = depth_r + LEN_W'(1);
  assign in_len_clamped = (in_prefix_length > MAX_LEN) ? MAX_LEN : in_prefix_length;
  assign rd_addr        = cmd.step ? child : '0;

  assign stat.is_query     = (op_r == OP_QUERY);
  assign stat.mark_hit     = rd_mark_r;
  assign stat.at_end       = (depth_r == len_r);
  assign stat.child_none   = (child == '0);
  assign stat.pool_short   = (AW'(needed) > free_nodes);
  assign stat.any_inserted = any_r;
  assign stat.create_last  = (depth_inc == len_r);
  assign stat.clr_last     = (clr_idx_r == LAST_ID);

  // Write port select: clearing sweep, child link, end mark
  always_comb begin
    wr_zero_en = 1'b0;
    wr_one_en  = 1'b0;
    wr_mark_en = 1'b0;
    wr_addr    = node_r;
    wr_ptr     = new_id;
    wr_mark    = 1'b1;
    if (cmd.clr) begin
      wr_zero_en = 1'b1;
      wr_one_en  = 1'b1;
      wr_mark_en = 1'b1;
      wr_addr    = clr_idx_r;
      wr_ptr     = '0;
      wr_mark    = 1'b0;
    end else if (cmd.create) begin
      wr_zero_en = ~cur_bit;
      wr_one_en  = cur_bit;
    end else if (cmd.mark) begin
      wr_mark_en = 1'b1;
    end
  end

  // Node memories, registered read
  always_ff @(posedge clk) begin
    if (wr_zero_en) zero_mem[wr_addr] <= wr_ptr;
    if (wr_one_en)  one_mem[wr_addr]  <= wr_ptr;
    if (wr_mark_en) mark_mem[wr_addr] <= wr_mark;
    rd_zero_r <= zero_mem[rd_addr];
    rd_one_r  <= one_mem[rd_addr];
    rd_mark_r <= mark_mem[rd_addr];
  end

  // Control state: sweep index, pool fill, insert flag, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r    <= '0;
      nodes_used_r <= '0;
      any_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr)    clr_idx_r    <= clr_idx_r + AW'(1);
      if (cmd.create) nodes_used_r <= new_id;
      if (cmd.mark)   any_r        <= 1'b1;
      out_valid_r <= cmd.emit;
    end
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      addr_r    <= in_prefix_address;
      addr_sh_r <= in_prefix_address;
      len_r     <= in_len_clamped;
      depth_r   <= '0;
      node_r    <= '0;
    end else if (cmd.step || cmd.create) begin
      addr_sh_r <= addr_sh_r << 1;
      depth_r   <= depth_inc;
      node_r    <= cmd.step ? child : new_id;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.res_kind)
        RES_INSERTED: begin
          out_status_r <= ST_INSERTED;
          out_addr_r   <= '0;
          out_len_r    <= '0;
        end
        RES_DROPPED: begin
          out_status_r <= ST_DROPPED;
          out_addr_r   <= '0;
          out_len_r    <= '0;
        end
        RES_SEP_WALK: begin
          out_status_r <= ST_SEPARABLE;
          out_addr_r   <= addr_r & top_mask(depth_inc);
          out_len_r    <= depth_inc;
        end
        RES_SEP_FULL: begin
          out_status_r <= ST_SEPARABLE;
          out_addr_r   <= addr_r & top_mask(len_r);
          out_len_r    <= len_r;
        end
        default: begin
          out_status_r <= ST_CONFLICT;
          out_addr_r   <= '0;
          out_len_r    <= '0;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_separating_address = out_addr_r;
  assign out_separating_length  = out_len_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ptcc_pkg::*;

  localparam int NODES       = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 80;
  localparam int MAX_REPORTS = 10;

  // One command beat as queued for the driver
  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    bit                drain;
  } prefix_cmd_t;

  // One result beat
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } trie_verdict_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_opcode = OP_INSERT;
  logic [ADDR_W-1:0] in_prefix_address = '0;
  logic [LEN_W-1:0]  in_prefix_length = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_separating_address;
  logic [LEN_W-1:0]  out_separating_length;

  prefix_cmd_t       cmd_q[$];
  trie_verdict_t     verdict_q[$];
  logic [ADDR_W-1:0] known_addrs[$];

  // Shadow trie
  bit [11:0] branch0 [NODES];
  bit [11:0] branch1 [NODES];
  bit        ends_here [NODES];
  int        alloc_count = 0;
  bit        seen_insert = 1'b0;

  bit beat_taken = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;
  int mismatches = 0;
  int cycle_count = 0;

  prefix_trie_conflict_check #(
    .NODE_COUNT (NODES)
  ) i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_opcode              (in_opcode),
    .in_prefix_address      (in_prefix_address),
    .in_prefix_length       (in_prefix_length),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_separating_address (out_separating_address),
    .out_separating_length  (out_separating_length)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Leading ones of the given count
  function automatic logic [ADDR_W-1:0] lead_mask(input int unsigned cnt);
    return 32'hFFFF_FFFF << (32 - cnt);
  endfunction

  // Walk/update the shadow trie for one accepted beat
  function automatic trie_verdict_t trie_judge(input logic op, input logic [ADDR_W-1:0] a,
                                               input logic [LEN_W-1:0] n);
    trie_verdict_t v;
    int unsigned   plen;
    int unsigned   depth;
    int unsigned   node;
    int unsigned   nxt;
    int unsigned   room;
    bit            stop;
    logic          br;
    v = '{ST_INSERTED, '0, '0};
    plen = (n > MAX_LEN) ? MAX_LEN : n;
    node = 0;
    depth = 0;
    stop = 1'b0;
    if (op == OP_INSERT) begin
      // follow the existing part of the path
      while (depth < plen && !stop) begin
        br = a[31 - depth];
        nxt = br ? branch1[node] : branch0[node];
        if (nxt == 0) begin
          stop = 1'b1;
        end else begin
          node = nxt;
          depth++;
        end
      end
      room = NODES - 1 - alloc_count;
      if (plen - depth > room) begin
        v.status = ST_DROPPED;
      end else begin
        for (int unsigned i = depth; i < plen; i++) begin
          alloc_count++;
          if (a[31 - i]) branch1[node] = 12'(alloc_count);
          else branch0[node] = 12'(alloc_count);
          node = alloc_count;
        end
        ends_here[node] = 1'b1;
        seen_insert = 1'b1;
      end
    end else begin
      if (ends_here[0]) begin
        v.status = ST_CONFLICT;
        stop = 1'b1;
      end
      while (depth < plen && !stop) begin
        br = a[31 - depth];
        node = br ? branch1[node] : branch0[node];
        if (node == 0) begin
          v.status = ST_SEPARABLE;
          v.len = LEN_W'(depth + 1);
          v.addr = a & lead_mask(depth + 1);
          stop = 1'b1;
        end else if (ends_here[node]) begin
          v.status = ST_CONFLICT;
          stop = 1'b1;
        end
        depth++;
      end
      if (!stop) begin
        if (seen_insert) begin
          v.status = ST_CONFLICT;
        end else begin
          v.status = ST_SEPARABLE;
          v.len = LEN_W'(plen);
          v.addr = a & lead_mask(plen);
        end
      end
    end
    return v;
  endfunction

  task automatic add_cmd(input logic op, input logic [ADDR_W-1:0] a,
                         input logic [LEN_W-1:0] n, input bit drain);
    cmd_q.push_back('{op, a, n, drain});
    if (op == OP_INSERT) known_addrs.push_back(a);
  endtask

  // Driver: bursts of beats with random gaps, changes on the falling edge
  always @(negedge clk) begin
    prefix_cmd_t c;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // hold the beat until taken
    end else if (gap_left > 0 || cmd_q.size() == 0 ||
                 (cmd_q[0].drain && verdict_q.size() != 0)) begin
      if (gap_left > 0) gap_left--;
      start <= 1'b0;
      in_opcode <= 1'($urandom_range(0, 1));
      in_prefix_address <= $urandom;
      in_prefix_length <= LEN_W'($urandom_range(0, 63));
    end else begin
      c = cmd_q.pop_front();
      start <= 1'b1;
      in_opcode <= c.op;
      in_prefix_address <= c.addr;
      in_prefix_length <= c.len;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(30, 80);
        else gap_left = $urandom_range(0, 15);
      end
    end
  end

  // Monitor: check result beats, predict accepted command beats
  always @(posedge clk) begin
    trie_verdict_t want;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected beat: status %0d addr %h len %0d",
                     out_status, out_separating_address, out_separating_length);
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status || out_separating_address !== want.addr ||
              out_separating_length !== want.len) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: exp status %0d addr %h len %0d, ",
                        "got status %0d addr %h len %0d"},
                       want.status, want.addr, want.len,
                       out_status, out_separating_address, out_separating_length);
          end
        end
      end
      beat_taken <= start && !busy;
      if (start && !busy)
        verdict_q.push_back(trie_judge(in_opcode, in_prefix_address, in_prefix_length));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] base;
    int unsigned       d;
    int unsigned       k;
    bit                drain;

    // Directed: empty trie, clamped lengths, exact and partial walks
    add_cmd(OP_QUERY,  32'h1234_5678, 6'd0,  1'b0);
    add_cmd(OP_QUERY,  32'hFFFF_FFFF, 6'd32, 1'b0);
    add_cmd(OP_QUERY,  32'h0000_0000, 6'd63, 1'b0);
    add_cmd(OP_INSERT, 32'hC0A8_0000, 6'd16, 1'b0);
    add_cmd(OP_QUERY,  32'hC0A8_1234, 6'd32, 1'b0);
    add_cmd(OP_QUERY,  32'hC0A8_0000, 6'd8,  1'b0);
    add_cmd(OP_QUERY,  32'hC0A9_0000, 6'd24, 1'b0);
    add_cmd(OP_QUERY,  32'h5A5A_5A5A, 6'd0,  1'b0);
    add_cmd(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1);
    add_cmd(OP_INSERT, 32'h0000_0000, 6'd63, 1'b0);
    add_cmd(OP_INSERT, 32'hAAAA_AAAA, 6'd33, 1'b0);
    add_cmd(OP_QUERY,  32'hFFFF_FFFE, 6'd32, 1'b0);
    add_cmd(OP_QUERY,  32'h0000_0000, 6'd40, 1'b0);
    add_cmd(OP_QUERY,  32'hAAAA_AAAB, 6'd63, 1'b0);
    add_cmd(OP_INSERT, 32'hC0A8_0000, 6'd16, 1'b0);
    add_cmd(OP_INSERT, 32'h5555_5555, 6'd20, 1'b0);
    add_cmd(OP_QUERY,  32'h5555_5555, 6'd12, 1'b0);
    add_cmd(OP_QUERY,  32'h5555_F000, 6'd31, 1'b0);

    // Random: inserts fill the pool, queries mostly follow known paths
    for (int n = 0; n < 1320; n++) begin
      k = $urandom_range(0, 99);
      drain = ($urandom_range(0, 249) == 0);
      base = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      if (k < 15) begin
        d = $urandom_range(8, 31);
        add_cmd(OP_INSERT, base ^ ($urandom & (32'hFFFF_FFFF >> d)),
                LEN_W'($urandom_range(d, 32)), drain);
      end else if (k < 38) begin
        add_cmd(OP_INSERT, $urandom, LEN_W'($urandom_range(12, 32)), drain);
      end else if (k < 45) begin
        add_cmd(OP_INSERT, $urandom, LEN_W'($urandom_range(33, 63)), drain);
      end else if (k < 75) begin
        d = $urandom_range(0, 31);
        if ($urandom_range(0, 9) == 0)
          add_cmd(OP_QUERY, base ^ (32'h8000_0000 >> d),
                  LEN_W'($urandom_range(33, 63)), drain);
        else
          add_cmd(OP_QUERY, base ^ (32'h8000_0000 >> d),
                  LEN_W'($urandom_range(d + 1, 32)), drain);
      end else if (k < 88) begin
        add_cmd(OP_QUERY, base, LEN_W'($urandom_range(1, 63)), drain);
      end else begin
        add_cmd(OP_QUERY, $urandom, LEN_W'($urandom_range(0, 63)), drain);
      end
    end

    // Directed tail: one-bit prefix, then a zero-length insert marks the root
    add_cmd(OP_QUERY,  32'hFFFF_FFFF, 6'd32, 1'b0);
    add_cmd(OP_INSERT, 32'h8000_0000, 6'd1,  1'b0);
    add_cmd(OP_QUERY,  32'hC000_0000, 6'd2,  1'b0);
    add_cmd(OP_QUERY,  32'h0000_0000, 6'd5,  1'b0);
    add_cmd(OP_INSERT, $urandom,      6'd0,  1'b1);
    add_cmd(OP_QUERY,  32'h0000_0000, 6'd0,  1'b0);
    add_cmd(OP_QUERY,  $urandom,      6'd63, 1'b0);
    add_cmd(OP_QUERY,  32'h7FFF_FFFF, 6'd32, 1'b0);

    // Reset, then let the driver run
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || start || verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
